@@ rtl/cbrm_pkg.sv @@
// ----------------------------------------------------------------------------
// cbrm_pkg
// Shared types and codes for the cubic Bezier relative mover: input command
// codes, configuration register indexes, multiply step codes and the command
// bundle that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package cbrm_pkg;

  // Input command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CTRL1_X = 3'd0,
    CFG_CTRL1_Y = 3'd1,
    CFG_CTRL2_X = 3'd2,
    CFG_CTRL2_Y = 3'd3,
    CFG_END_X   = 3'd4,
    CFG_END_Y   = 3'd5
  } cfg_idx_t;

  // Multiply steps in issue order; each product is consumed in the cycle after its issue
  localparam int STEP_W = 4;

  typedef enum logic [STEP_W-1:0] {
    STEP_TT  = 4'd0,   // t * t
    STEP_UU  = 4'd1,   // u * u
    STEP_W3  = 4'd2,   // tt * t
    STEP_W1  = 4'd3,   // uu * t, weighted by three
    STEP_W2  = 4'd4,   // tt * u, weighted by three
    STEP_C1X = 4'd5,   // w1 * ctrl1_x
    STEP_C2X = 4'd6,   // w2 * ctrl2_x
    STEP_EX  = 4'd7,   // w3 * end_x
    STEP_C1Y = 4'd8,   // w1 * ctrl1_y
    STEP_C2Y = 4'd9,   // w2 * ctrl2_y
    STEP_EY  = 4'd10   // w3 * end_y
  } step_t;

  // Last run count: the step after the last issue, in which the product register drains
  localparam logic [STEP_W-1:0] RUN_LAST = 4'd11;

  // Controller to datapath commands
  typedef struct packed {
    logic  latch;     // start item: take current position as origin and last
    logic  load;      // update item: capture time and position
    logic  drift;     // shift origin by outside movement
    logic  mul_go;    // issue a multiply this cycle
    step_t mul_step;  // which multiply
    logic  finish;    // form new position into the output register
  } cmd_t;

endpackage

@@ rtl/cbrm_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbrm_ctrl
// Sequencer for the mover: handles the input and result handshakes and steps
// the datapath through the shared-multiplier schedule.
// ----------------------------------------------------------------------------
module cbrm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic               in_halted,
  output logic               out_valid,
  input  logic               out_ready,
  output cbrm_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  state_t                          state_r;
  logic [cbrm_pkg::STEP_W-1:0]     cnt_r;
  logic                            out_valid_r;
  logic                            accept;
  logic                            do_update;
  logic                            fin_go;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign do_update = (in_command == cbrm_pkg::CMD_UPDATE) && !in_halted;
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // Decode datapath commands from state and count
  always_comb begin
    cmd.latch    = accept && (in_command == cbrm_pkg::CMD_START);
    cmd.load     = accept && do_update;
    cmd.drift    = (state_r == ST_RUN) && (cnt_r == '0);
    cmd.mul_go   = (state_r == ST_RUN) && (cnt_r <= cbrm_pkg::STEP_EY);
    cmd.mul_step = cmd.mul_go ? cbrm_pkg::step_t'(cnt_r) : cbrm_pkg::STEP_TT;
    cmd.finish   = fin_go;
  end

  // State, step count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise the result as it lands; drop it once transferred
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (accept && do_update) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == cbrm_pkg::RUN_LAST) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Hold until the result register is free
          if (fin_go) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/cbrm_dp.sv @@
// ----------------------------------------------------------------------------
// cbrm_dp
// Datapath for the mover: configuration registers, position state, one shared
// signed multiplier with a product register, weight and offset accumulation,
// saturation and the result register.
// ----------------------------------------------------------------------------
module cbrm_dp #(
  parameter int COORD_BITS     = 24,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cbrm_pkg::cmd_t                   cmd,
  input  logic [TIME_FRAC_BITS:0]          in_time_frac,
  input  logic signed [COORD_BITS-1:0]     in_cur_x,
  input  logic signed [COORD_BITS-1:0]     in_cur_y,
  input  logic                             cfg_we,
  input  logic [cbrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]            cfg_data,
  output logic signed [COORD_BITS-1:0]     out_new_x,
  output logic signed [COORD_BITS-1:0]     out_new_y
);

  localparam int C  = COORD_BITS;
  localparam int F  = TIME_FRAC_BITS;
  localparam int TW = F + 1;                       // time and weight width
  localparam int BW = (C > TW + 1) ? C : TW + 1;   // multiplier B operand
  localparam int PW = TW + 1 + BW;                 // product width
  localparam int AW = TW + C + 1;                  // offset accumulator width
  localparam int UW = 2 * TW + 2;                  // weight rounding width
  localparam int SW = C + 2;                       // pre-saturation width

  localparam logic [TW-1:0]          ONE_T  = TW'(1) << F;
  localparam logic [UW-1:0]          HALF_U = UW'(1) << (F - 1);
  localparam logic signed [AW-1:0]   HALF_S = AW'(1) << (F - 1);
  localparam logic signed [C-1:0]    CMAX   = {1'b0, {(C-1){1'b1}}};
  localparam logic signed [C-1:0]    CMIN   = {1'b1, {(C-1){1'b0}}};
  localparam logic signed [SW-1:0]   CMAX_E = SW'(CMAX);
  localparam logic signed [SW-1:0]   CMIN_E = SW'(CMIN);

  // Clamp to the signed coordinate range
  function automatic logic signed [C-1:0] sat_f(input logic signed [SW-1:0] v);
    logic signed [C-1:0] r;
    if (v > CMAX_E) begin
      r = CMAX;
    end else if (v < CMIN_E) begin
      r = CMIN;
    end else begin
      r = v[C-1:0];
    end
    return r;
  endfunction

  // Configuration
  logic signed [C-1:0] ctrl1_x_r, ctrl1_y_r, ctrl2_x_r, ctrl2_y_r, end_x_r, end_y_r;

  // Position state
  logic signed [C-1:0] origin_x_r, origin_y_r, last_x_r, last_y_r;
  logic signed [C-1:0] cur_x_r, cur_y_r;

  // Time terms and weights
  logic [TW-1:0] t_r, u_r, tt_r, uu_r, w1_r, w2_r, w3_r;
  logic [TW-1:0] t_cl;

  // Multiplier
  logic [TW-1:0]          wa;
  logic [TW-1:0]          tb;
  logic signed [C-1:0]    cb;
  logic                   use_c;
  logic signed [TW:0]     ma;
  logic signed [BW-1:0]   mb_c;
  logic signed [BW-1:0]   mb_t;
  logic signed [BW-1:0]   mb;
  logic signed [PW-1:0]   prod_r;
  logic                   pvld_r;
  cbrm_pkg::step_t        pstep_r;

  // Product consumption
  logic [UW-1:0]          u1;
  logic [UW-1:0]          rnd1;
  logic [UW-1:0]          rnd3;
  logic [TW-1:0]          r1;
  logic [TW-1:0]          r3;
  logic signed [AW-1:0]   ps;
  logic signed [AW-1:0]   sum_a;
  logic signed [AW-1:0]   acc_r;
  logic signed [C-1:0]    offx_r, offy_r;

  // Position arithmetic
  logic signed [SW-1:0]   drift_x, drift_y;
  logic signed [C-1:0]    new_x, new_y;
  logic signed [C-1:0]    out_new_x_r, out_new_y_r;

  assign out_new_x = out_new_x_r;
  assign out_new_y = out_new_y_r;

  // Clamp time to one
  assign t_cl = (in_time_frac > ONE_T) ? ONE_T : in_time_frac;

  // Select multiplier operands
  always_comb begin
    wa    = t_r;
    tb    = t_r;
    cb    = ctrl1_x_r;
    use_c = 1'b0;
    unique case (cmd.mul_step)
      cbrm_pkg::STEP_TT:  begin wa = t_r;  tb = t_r;                   end
      cbrm_pkg::STEP_UU:  begin wa = u_r;  tb = u_r;                   end
      cbrm_pkg::STEP_W3:  begin wa = tt_r; tb = t_r;                   end
      cbrm_pkg::STEP_W1:  begin wa = uu_r; tb = t_r;                   end
      cbrm_pkg::STEP_W2:  begin wa = tt_r; tb = u_r;                   end
      cbrm_pkg::STEP_C1X: begin wa = w1_r; cb = ctrl1_x_r; use_c = 1'b1; end
      cbrm_pkg::STEP_C2X: begin wa = w2_r; cb = ctrl2_x_r; use_c = 1'b1; end
      cbrm_pkg::STEP_EX:  begin wa = w3_r; cb = end_x_r;   use_c = 1'b1; end
      cbrm_pkg::STEP_C1Y: begin wa = w1_r; cb = ctrl1_y_r; use_c = 1'b1; end
      cbrm_pkg::STEP_C2Y: begin wa = w2_r; cb = ctrl2_y_r; use_c = 1'b1; end
      cbrm_pkg::STEP_EY:  begin wa = w3_r; cb = end_y_r;   use_c = 1'b1; end
      default: begin
        wa = t_r;
      end
    endcase
  end

  assign ma   = $signed({1'b0, wa});
  assign mb_c = BW'(cb);
  assign mb_t = $signed(BW'(tb));
  assign mb   = use_c ? mb_c : mb_t;

  // Round the registered product: plain, tripled, or into the accumulator
  assign u1    = UW'(prod_r[2*TW-1:0]);
  assign rnd1  = u1 + HALF_U;
  assign rnd3  = (u1 << 1) + u1 + HALF_U;
  assign r1    = rnd1[F +: TW];
  assign r3    = rnd3[F +: TW];
  assign ps    = $signed(prod_r[AW-1:0]);
  assign sum_a = acc_r + ps;

  // Shift origin by outside movement; form the new position
  assign drift_x = SW'(origin_x_r) + SW'(cur_x_r) - SW'(last_x_r);
  assign drift_y = SW'(origin_y_r) + SW'(cur_y_r) - SW'(last_y_r);
  assign new_x   = sat_f(SW'(origin_x_r) + SW'(offx_r));
  assign new_y   = sat_f(SW'(origin_y_r) + SW'(offy_r));

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl1_x_r <= '0;
      ctrl1_y_r <= '0;
      ctrl2_x_r <= '0;
      ctrl2_y_r <= '0;
      end_x_r   <= '0;
      end_y_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbrm_pkg::CFG_CTRL1_X: ctrl1_x_r <= cfg_data;
        cbrm_pkg::CFG_CTRL1_Y: ctrl1_y_r <= cfg_data;
        cbrm_pkg::CFG_CTRL2_X: ctrl2_x_r <= cfg_data;
        cbrm_pkg::CFG_CTRL2_Y: ctrl2_y_r <= cfg_data;
        cbrm_pkg::CFG_END_X:   end_x_r   <= cfg_data;
        cbrm_pkg::CFG_END_Y:   end_y_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Origin and last position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      last_x_r   <= '0;
      last_y_r   <= '0;
    end else begin
      if (cmd.latch) begin
        origin_x_r <= in_cur_x;
        origin_y_r <= in_cur_y;
        last_x_r   <= in_cur_x;
        last_y_r   <= in_cur_y;
      end else if (cmd.drift) begin
        origin_x_r <= sat_f(drift_x);
        origin_y_r <= sat_f(drift_y);
      end else if (cmd.finish) begin
        last_x_r <= new_x;
        last_y_r <= new_y;
      end
    end
  end

  // Capture the update item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r     <= t_cl;
      u_r     <= ONE_T - t_cl;
      cur_x_r <= in_cur_x;
      cur_y_r <= in_cur_y;
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod_r  <= ma * mb;
      pstep_r <= cmd.mul_step;
    end
  end

  // Consume the product issued last cycle
  always_ff @(posedge clk) begin
    if (pvld_r) begin
      unique case (pstep_r)
        cbrm_pkg::STEP_TT:  tt_r   <= r1;
        cbrm_pkg::STEP_UU:  uu_r   <= r1;
        cbrm_pkg::STEP_W3:  w3_r   <= r1;
        cbrm_pkg::STEP_W1:  w1_r   <= r3;
        cbrm_pkg::STEP_W2:  w2_r   <= r3;
        cbrm_pkg::STEP_C1X: acc_r  <= ps + HALF_S;
        cbrm_pkg::STEP_C2X: acc_r  <= sum_a;
        cbrm_pkg::STEP_EX:  offx_r <= sat_f(sum_a[AW-1:F]);
        cbrm_pkg::STEP_C1Y: acc_r  <= ps + HALF_S;
        cbrm_pkg::STEP_C2Y: acc_r  <= sum_a;
        cbrm_pkg::STEP_EY:  offy_r <= sat_f(sum_a[AW-1:F]);
        default: begin
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_new_x_r <= new_x;
      out_new_y_r <= new_y;
    end
  end

endmodule

@@ rtl/cubic_bezier_relative_mover_top.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_relative_mover_top
// Moves an object along a 2D cubic Bezier offset from a latched start point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_command selects start or update.
//   A start transfer latches in_cur_x/in_cur_y as origin and last position
//   and gives no result; a halted update is taken and dropped.
//   An update transfer gives one result on out_valid/out_ready: new_x/new_y.
//   An update holds the input until its result is formed; start and halted
//   items do not hold it. The schedule is eleven dependent multiplies on one
//   shared multiplier, each consumed in the cycle after its issue.
//   The result sits in an output register; a new item is taken while it
//   waits. If the receiver stalls, the next update holds in its last step
//   until the register frees.
//   Configuration (cfg_we/cfg_index/cfg_data) is to be written by the user
//   only while idle; the block itself does not enforce it.
//   Reset (rst_n low, synchronous) clears configuration, origin and last
//   position to zero and drops any pending result.
// ----------------------------------------------------------------------------
module cubic_bezier_relative_mover_top #(
  parameter int COORD_BITS     = 24,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_command,
  input  logic                             in_halted,
  input  logic [TIME_FRAC_BITS:0]          in_time_frac,
  input  logic signed [COORD_BITS-1:0]     in_cur_x,
  input  logic signed [COORD_BITS-1:0]     in_cur_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [COORD_BITS-1:0]     out_new_x,
  output logic signed [COORD_BITS-1:0]     out_new_y,
  input  logic                             cfg_we,
  input  logic [cbrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]            cfg_data
);

  cbrm_pkg::cmd_t cmd;

  // Sequencer
  cbrm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_halted  (in_halted),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd)
  );

  // Arithmetic and state
  cbrm_dp #(
    .COORD_BITS     (COORD_BITS),
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_time_frac (in_time_frac),
    .in_cur_x     (in_cur_x),
    .in_cur_y     (in_cur_y),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_new_x    (out_new_x),
    .out_new_y    (out_new_y)
  );

endmodule

@@ rtl/cbrm_chk.sv @@
// ----------------------------------------------------------------------------
// cbrm_chk
// Port-level checks for the mover, bound to the top level.
// ----------------------------------------------------------------------------
module cbrm_chk #(
  parameter int COORD_BITS = 24
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_command,
  input logic                         in_halted,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [COORD_BITS-1:0] out_new_x,
  input logic signed [COORD_BITS-1:0] out_new_y
);

  logic in_xfer;
  logic upd_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign upd_xfer = in_xfer && (in_command == cbrm_pkg::CMD_UPDATE) && !in_halted;

  // An update blocks the input while it runs
  a_upd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    upd_xfer |=> !in_ready)
    else $error("input ready right after an update transfer");

  // The input is still blocked once the multiply schedule is through
  a_upd_span: assert property (@(posedge clk) disable iff (!rst_n)
    upd_xfer |-> ##13 !in_ready)
    else $error("update finished too early");

  // Start and halted items never produce a result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !upd_xfer && !out_valid) |=> !out_valid)
    else $error("result after a start or halted item");

  // A result appears only as the block goes idle
  a_rise_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while busy");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_new_x) && $stable(out_new_y)))
    else $error("stalled result changed");

endmodule

bind cubic_bezier_relative_mover_top cbrm_chk #(
  .COORD_BITS (COORD_BITS)
) u_cbrm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_command (in_command),
  .in_halted  (in_halted),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_new_x  (out_new_x),
  .out_new_y  (out_new_y)
);

@@ bench/cubic_bezier_relative_mover_checker.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_relative_mover_checker
// Watches the input, result and configuration ports of the Bezier mover.
// Keeps its own copy of the curve registers and of the start and previous
// positions, predicts the new position for every update transfer that is not
// halted, and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module cubic_bezier_relative_mover_checker #(
  parameter int COORD_BITS     = 24,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_command,
  input  logic                            in_halted,
  input  logic [TIME_FRAC_BITS:0]         in_time_frac,
  input  logic signed [COORD_BITS-1:0]    in_cur_x,
  input  logic signed [COORD_BITS-1:0]    in_cur_y,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic signed [COORD_BITS-1:0]    out_new_x,
  input  logic signed [COORD_BITS-1:0]    out_new_y,
  input  logic                            cfg_we,
  input  logic [cbrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0]           cfg_data,
  output int                              pending_moves,
  output int                              fail_count
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint T_ONE   = longint'(1) << TIME_FRAC_BITS;
  localparam longint T_HALF  = longint'(1) << (TIME_FRAC_BITS - 1);
  localparam longint POS_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint POS_MIN = -POS_MAX - 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] new_x;
    logic signed [COORD_BITS-1:0] new_y;
  } position_t;

  // Curve registers and mover state
  longint ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y;
  longint start_x, start_y, prev_x, prev_y;

  position_t expected_positions[$];
  int        mismatches = 0;

  function automatic longint clip(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // Round half up to the time fraction: add half an LSB, then floor
  function automatic longint round_frac(longint p);
    return (p + T_HALF) >>> TIME_FRAC_BITS;
  endfunction

  // Evaluate the curve at t, fold outside movement into the start position,
  // and advance the previous position to the new one
  function automatic position_t move_along(logic [TIME_FRAC_BITS:0] t_raw,
                                           longint cx, longint cy);
    longint    t, u, tt, uu, w1, w2, w3, off_x, off_y;
    position_t p;
    t = longint'(t_raw);
    if (t > T_ONE) t = T_ONE;
    u  = T_ONE - t;
    tt = round_frac(t * t);
    uu = round_frac(u * u);
    w1 = round_frac(3 * t * uu);
    w2 = round_frac(3 * tt * u);
    w3 = round_frac(tt * t);
    off_x = clip(round_frac(w1 * ctrl1_x + w2 * ctrl2_x + w3 * end_x));
    off_y = clip(round_frac(w1 * ctrl1_y + w2 * ctrl2_y + w3 * end_y));
    start_x = clip(start_x + (cx - prev_x));
    start_y = clip(start_y + (cy - prev_y));
    prev_x  = clip(start_x + off_x);
    prev_y  = clip(start_y + off_y);
    p.new_x = prev_x[COORD_BITS-1:0];
    p.new_y = prev_y[COORD_BITS-1:0];
    return p;
  endfunction

  // Track writes and transfers on every rising edge
  always @(posedge clk) begin
    position_t want;
    longint    wdata;
    if (!rst_n) begin
      ctrl1_x = 0; ctrl1_y = 0; ctrl2_x = 0; ctrl2_y = 0; end_x = 0; end_y = 0;
      start_x = 0; start_y = 0; prev_x = 0; prev_y = 0;
      expected_positions.delete();
    end else begin
      // Configuration write; spare indexes are dropped
      if (cfg_we) begin
        wdata = longint'(signed'(cfg_data));
        case (cfg_index)
          cbrm_pkg::CFG_CTRL1_X: ctrl1_x = wdata;
          cbrm_pkg::CFG_CTRL1_Y: ctrl1_y = wdata;
          cbrm_pkg::CFG_CTRL2_X: ctrl2_x = wdata;
          cbrm_pkg::CFG_CTRL2_Y: ctrl2_y = wdata;
          cbrm_pkg::CFG_END_X:   end_x   = wdata;
          cbrm_pkg::CFG_END_Y:   end_y   = wdata;
          default: ;
        endcase
      end

      // Input transfer: a start latches even when halted
      if (in_valid && in_ready) begin
        if (in_command == cbrm_pkg::CMD_START) begin
          start_x = longint'(in_cur_x);
          start_y = longint'(in_cur_y);
          prev_x  = start_x;
          prev_y  = start_y;
        end else if (!in_halted) begin
          expected_positions.push_back(move_along(in_time_frac,
                                                  longint'(in_cur_x),
                                                  longint'(in_cur_y)));
        end
      end

      // Result transfer against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_positions.size() == 0) begin
          $error("unexpected result: new_x=%0d new_y=%0d", out_new_x, out_new_y);
          mismatches++;
        end else begin
          want = expected_positions.pop_front();
          if (out_new_x !== want.new_x) begin
            $error("new_x mismatch: expected %0d, got %0d", want.new_x, out_new_x);
            mismatches++;
          end
          if (out_new_y !== want.new_y) begin
            $error("new_y mismatch: expected %0d, got %0d", want.new_y, out_new_y);
            mismatches++;
          end
        end
      end
    end
    pending_moves <= expected_positions.size();
    fail_count    <= mismatches;
  end

endmodule

@@ bench/cubic_bezier_relative_mover_top_tb.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_relative_mover_top_tb
// Drives the Bezier mover with directed corner cases and then with random
// moves (a start followed by updates sweeping time forward) plus noise items,
// under several curve settings and three idle patterns, including a long
// receiver hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module cubic_bezier_relative_mover_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW            = 24;
  localparam int TF            = 16;
  localparam int TW            = TF + 1;
  localparam int T_ONE         = 1 << TF;
  localparam int T_TOP         = (1 << (TF + 1)) - 1;
  localparam int SPAN          = 1 << 20;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [cbrm_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [cbrm_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_command;
  logic                            in_halted;
  logic [TF:0]                     in_time_frac;
  logic signed [CW-1:0]            in_cur_x;
  logic signed [CW-1:0]            in_cur_y;
  logic                            out_valid;
  logic                            out_ready;
  logic signed [CW-1:0]            out_new_x;
  logic signed [CW-1:0]            out_new_y;
  logic                            cfg_we;
  logic [cbrm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [CW-1:0]                   cfg_data;

  int pending_moves;
  int fail_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int cycle_count;

  cubic_bezier_relative_mover_top #(
    .COORD_BITS     (CW),
    .TIME_FRAC_BITS (TF)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_halted    (in_halted),
    .in_time_frac (in_time_frac),
    .in_cur_x     (in_cur_x),
    .in_cur_y     (in_cur_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_new_x    (out_new_x),
    .out_new_y    (out_new_y),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  cubic_bezier_relative_mover_checker #(
    .COORD_BITS     (CW),
    .TIME_FRAC_BITS (TF)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_halted     (in_halted),
    .in_time_frac  (in_time_frac),
    .in_cur_x      (in_cur_x),
    .in_cur_y      (in_cur_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_new_x     (out_new_x),
    .out_new_y     (out_new_y),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending_moves (pending_moves),
    .fail_count    (fail_count)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** cubic_bezier_relative_mover_top: FAILED **");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int seen_req;
    hold_left = 0;
    seen_req  = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != seen_req) begin
        seen_req  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one item; return right after its transfer edge
  task automatic offer(input logic cmd, input logic hlt, input logic [TF:0] t,
                       input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_halted    <= hlt;
    in_time_frac <= t;
    in_cur_x     <= x;
    in_cur_y     <= y;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for all results, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_moves != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input logic [cbrm_pkg::CFG_IDX_W-1:0] idx,
                         input logic [CW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Write all six curve registers, then a spare index that must be ignored
  task automatic load_curve(input logic signed [CW-1:0] c1x, input logic signed [CW-1:0] c1y,
                            input logic signed [CW-1:0] c2x, input logic signed [CW-1:0] c2y,
                            input logic signed [CW-1:0] ex, input logic signed [CW-1:0] ey);
    put_reg(cbrm_pkg::CFG_CTRL1_X, c1x);
    put_reg(cbrm_pkg::CFG_CTRL1_Y, c1y);
    put_reg(cbrm_pkg::CFG_CTRL2_X, c2x);
    put_reg(cbrm_pkg::CFG_CTRL2_Y, c2y);
    put_reg(cbrm_pkg::CFG_END_X, ex);
    put_reg(cbrm_pkg::CFG_END_Y, ey);
    put_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, CW'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Mostly moderate coordinates, some anywhere, some at the extremes
  function automatic logic signed [CW-1:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 70) return CW'(int'($urandom_range(0, 2 * SPAN)) - SPAN);
    if (r < 85) return CW'($urandom);
    case ($urandom_range(3))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Small outside movement, often none
  function automatic logic signed [CW-1:0] nudge(logic signed [CW-1:0] c);
    if ($urandom_range(99) < 60) return c;
    return CW'(int'(c) + (int'($urandom_range(0, 2048)) - 1024));
  endfunction

  task automatic load_random_curve();
    load_curve(pick_coord(), pick_coord(), pick_coord(),
               pick_coord(), pick_coord(), pick_coord());
  endtask

  // Moves: latch a start, then sweep time forward; some noise items between
  task automatic run_moves(input int n_items);
    int                   sent;
    int                   steps;
    int                   tv;
    logic signed [CW-1:0] px, py;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        offer(1'($urandom_range(1)), 1'($urandom_range(1)), TW'($urandom),
              CW'($urandom), CW'($urandom));
        sent++;
      end else begin
        px = pick_coord();
        py = pick_coord();
        offer(cbrm_pkg::CMD_START, 1'($urandom_range(1)), TW'($urandom), px, py);
        steps = $urandom_range(1, 12);
        tv    = 0;
        for (int k = 0; k < steps; k++) begin
          tv += $urandom_range(0, 2 * T_ONE / steps);
          if (tv > T_TOP) tv = T_TOP;
          offer(cbrm_pkg::CMD_UPDATE, ($urandom_range(99) < 8), TW'(tv),
                nudge(px), nudge(py));
        end
        sent += steps + 1;
      end
    end
  endtask

  // Two curve settings per idle pattern
  task automatic run_phase(input int n_items, input bit with_hold);
    for (int half = 0; half < 2; half++) begin
      settle();
      load_random_curve();
      if (with_hold && half == 0) hold_req <= hold_req + 1;
      run_moves(n_items / 2);
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = cbrm_pkg::CMD_START;
    in_halted     = 1'b0;
    in_time_frac  = '0;
    in_cur_x      = '0;
    in_cur_y      = '0;
    cfg_we        = 1'b0;
    cfg_index     = cbrm_pkg::CFG_CTRL1_X;
    cfg_data      = '0;
    hold_req      = 0;
    send_idle_pct = 29;
    recv_idle_pct = 29;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    recv_idle_pct <= 84;
    @(negedge clk);

    // Moderate curve: time corners, halted cases, outside movement
    load_curve(24'sd25600, -24'sd12800, -24'sd7680, 24'sd51200, 24'sd102400, 24'sd76800);
    offer(cbrm_pkg::CMD_START, 1'b1, TW'(T_ONE), 24'sd256000, -24'sd128000);
    offer(cbrm_pkg::CMD_UPDATE, 1'b0, '0, 24'sd256000, -24'sd128000);
    offer(cbrm_pkg::CMD_UPDATE, 1'b0, TW'(T_ONE / 4), 24'sd256000, -24'sd128000);
    offer(cbrm_pkg::CMD_UPDATE, 1'b0, TW'(T_ONE / 2), 24'sd258560, -24'sd130560);
    offer(cbrm_pkg::CMD_UPDATE, 1'b1, TW'(3 * T_ONE / 4), 24'sd0, 24'sd0);
    offer(cbrm_pkg::CMD_UPDATE, 1'b0, TW'(T_ONE), 24'sd258560, -24'sd130560);
    offer(cbrm_pkg::CMD_UPDATE, 1'b0, TW'(T_ONE + 1), 24'sd258560, -24'sd130560);
    offer(cbrm_pkg::CMD_UPDATE, 1'b0, TW'(T_TOP), 24'sd258560, -24'sd130560);
    // Saturation at the top, then huge jumps of the object in both directions
    offer(cbrm_pkg::CMD_START, 1'b0, '0, COORD_MAX, COORD_MAX);
    offer(cbrm_pkg::CMD_UPDATE, 1'b0, TW'(T_ONE), COORD_MAX, COORD_MAX);
    offer(cbrm_pkg::CMD_START, 1'b0, '0, COORD_MIN, COORD_MIN);
    offer(cbrm_pkg::CMD_UPDATE, 1'b0, '0, COORD_MAX, COORD_MAX);
    offer(cbrm_pkg::CMD_UPDATE, 1'b0, TW'(T_ONE), COORD_MIN, COORD_MIN);

    // Largest curve
    settle();
    load_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    offer(cbrm_pkg::CMD_START, 1'b0, '0, 24'sd0, 24'sd0);
    offer(cbrm_pkg::CMD_UPDATE, 1'b0, TW'(T_ONE / 2), 24'sd0, 24'sd0);
    offer(cbrm_pkg::CMD_UPDATE, 1'b0, TW'(T_ONE), 24'sd0, 24'sd0);
    offer(cbrm_pkg::CMD_START, 1'b0, '0, COORD_MAX, COORD_MAX);
    offer(cbrm_pkg::CMD_UPDATE, 1'b0, TW'(T_ONE / 2), COORD_MAX, COORD_MAX);

    // Most negative curve
    settle();
    load_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    offer(cbrm_pkg::CMD_START, 1'b0, '0, COORD_MIN, COORD_MIN);
    offer(cbrm_pkg::CMD_UPDATE, 1'b0, TW'(T_ONE / 2), COORD_MIN, COORD_MIN);
    offer(cbrm_pkg::CMD_UPDATE, 1'b0, TW'(T_ONE), -24'sd1, -24'sd1);

    // Flat curve: the object stays put
    settle();
    load_curve('0, '0, '0, '0, '0, '0);
    offer(cbrm_pkg::CMD_START, 1'b0, '0, -24'sd1, -24'sd1);
    offer(cbrm_pkg::CMD_UPDATE, 1'b0, TW'(12345), -24'sd1, -24'sd1);

    // Random moves under the three idle patterns
    run_phase(300, 1'b0);
    settle();
    send_idle_pct = 84;
    recv_idle_pct <= 29;
    run_phase(300, 1'b0);
    settle();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_phase(330, 1'b1);

    settle();
    if (fail_count == 0 && pending_moves == 0)
      $display("** cubic_bezier_relative_mover_top: PASSED **");
    else
      $display("** cubic_bezier_relative_mover_top: FAILED **");
    $finish;
  end

endmodule
